// ===== rtl/core/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfp_pkg
// Field widths and operator codes for the constant fold/propagate core.
// ----------------------------------------------------------------------------
package cfp_pkg;

	localparam int KIND_BITS = 3;
	localparam int ID_BITS   = 5;
	localparam int LIT_BITS  = 32;

	typedef logic [KIND_BITS-1:0] kind_t;
	typedef logic [ID_BITS-1:0]   var_id_t;
	typedef logic [LIT_BITS-1:0]  lit_t;

	localparam kind_t K_ADD    = 3'd0;
	localparam kind_t K_SUB    = 3'd1;
	localparam kind_t K_MUL    = 3'd2;
	localparam kind_t K_DIV    = 3'd3;
	localparam kind_t K_ASSIGN = 3'd4;
	localparam kind_t K_OTHER  = 3'd5;

endpackage

// ===== rtl/core/constant_fold_propagate_core.sv =====
// ----------------------------------------------------------------------------
// constant_fold_propagate_core
// Substitutes known constants into three-address instructions, folds the
// computable ones and tracks which variables hold constants.
// ----------------------------------------------------------------------------
// An input transfer moves to S_RES, where the operands are resolved. Add, sub,
// assign, other and anything not folded then go to S_WB; a folded multiply first
// runs S_MUL (one 16-bit slice per cycle), and a folded divide first runs S_DIV
// (restoring, one bit/cycle) and then S_DFIN. One instruction in flight; the next
// input transfer is taken the cycle after the result enters the output register.
// Reset clears all known-constant bits at once; the value RAM is not cleared.
// ----------------------------------------------------------------------------
module constant_fold_propagate_core #(
	parameter int NUM_VARIABLES = 32,
	parameter int VALUE_BITS    = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    in_valid,
	output logic                    in_stall,
	input  cfp_pkg::kind_t          kind,
	input  logic                    first_is_literal,
	input  logic signed [31:0]      first_literal,
	input  cfp_pkg::var_id_t        first_variable,
	input  logic                    second_is_literal,
	input  logic signed [31:0]      second_literal,
	input  cfp_pkg::var_id_t        second_variable,
	input  cfp_pkg::var_id_t        target_variable,

	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    removed,
	output cfp_pkg::kind_t          out_kind,
	output logic                    out_first_is_literal,
	output logic signed [31:0]      out_first_literal,
	output cfp_pkg::var_id_t        out_first_variable,
	output logic                    out_second_is_literal,
	output logic signed [31:0]      out_second_literal,
	output cfp_pkg::var_id_t        out_second_variable,
	output cfp_pkg::var_id_t        out_target_variable,
	output logic signed [31:0]      folded_value
);

	localparam int VB  = VALUE_BITS;
	localparam int AW  = $clog2(NUM_VARIABLES);
	localparam int IXW = 9;
	localparam int MC  = (VB + 15) / 16;
	localparam int MW  = MC * 16;
	localparam int MCW = (MC > 1) ? $clog2(MC) : 1;
	localparam int DCW = $clog2(VB);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RES  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_DFIN = 3'd4;
	localparam logic [2:0] S_WB   = 3'd5;

	function automatic logic id_ok(input cfp_pkg::var_id_t id);
		return IXW'(id) < IXW'(NUM_VARIABLES);
	endfunction

	function automatic logic [AW-1:0] id_addr(input cfp_pkg::var_id_t id);
		logic [IXW-1:0] e;
		e = IXW'(id);
		return e[AW-1:0];
	endfunction

	function automatic logic [VB-1:0] lit_to_val(input cfp_pkg::lit_t l);
		logic [63:0] e;
		e = 64'($signed(l));
		return e[VB-1:0];
	endfunction

	function automatic cfp_pkg::lit_t val_to_32(input logic [VB-1:0] v);
		logic [63:0] e;
		e = 64'($signed(v));
		return e[31:0];
	endfunction

	function automatic logic [VB-1:0] magnitude(input logic [VB-1:0] v);
		return v[VB-1] ? (~v) + VB'(1) : v;
	endfunction

	logic [2:0]             state_q, state_d;
	logic [NUM_VARIABLES-1:0] known_q;
	logic [MCW-1:0]         mcnt_q;
	logic [DCW-1:0]         dcnt_q;

	cfp_pkg::kind_t         kind_q;
	logic                   fl_q, sl_q, ka_q, kb_q;
	cfp_pkg::lit_t          flit_q, slit_q;
	cfp_pkg::var_id_t       fvar_q, svar_q, tgt_q;
	logic [VB-1:0]          a_q, b_q, r_q, acc_q, dvs_q, rem_q;
	logic                   ca_q, cb_q, fold_q, neg_q;

	logic                   acc_in, wb_go, tgt_ok;
	logic [AW-1:0]          tgt_addr;
	logic [VB-1:0]          rd_a, rd_b, a_res, b_res;
	logic                   ca, cb, mul_go, div_go, mul_last, div_last;
	logic [MW-1:0]          b_sh;
	logic [VB+15:0]         prod;
	logic [VB-1:0]          part;
	logic [VB:0]            div_t, div_sub;
	logic                   div_ge;

	assign in_stall = (state_q != S_IDLE);
	assign acc_in   = in_valid && !in_stall;
	assign wb_go    = (state_q == S_WB) && (!out_valid || !out_stall);
	assign tgt_ok   = id_ok(tgt_q);
	assign tgt_addr = id_addr(tgt_q);

	cfp_ram #(
		.WIDTH(VB),
		.DEPTH(NUM_VARIABLES)
	) u_values (
		.clk    (clk),
		.we     (wb_go && fold_q && tgt_ok),
		.waddr  (tgt_addr),
		.wdata  (r_q),
		.raddr_a(id_addr(first_variable)),
		.raddr_b(id_addr(second_variable)),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	// operand resolve; RAM data belongs to the read issued at the transfer
	assign a_res  = fl_q ? lit_to_val(flit_q) : rd_a;
	assign b_res  = sl_q ? lit_to_val(slit_q) : rd_b;
	assign ca     = fl_q || ka_q;
	assign cb     = sl_q || kb_q;
	assign mul_go = ca && cb;
	assign div_go = ca && cb && (b_res != '0);

	assign mul_last = (mcnt_q == MCW'(MC - 1));
	assign div_last = (dcnt_q == DCW'(VB - 1));

	assign b_sh = MW'(b_q) >> {mcnt_q, 4'd0};
	assign prod = (VB + 16)'(a_q) * (VB + 16)'(b_sh[15:0]);
	assign part = prod[VB-1:0] << {mcnt_q, 4'd0};

	assign div_t   = {rem_q, acc_q[VB-1]};
	assign div_sub = div_t - {1'b0, dvs_q};
	assign div_ge  = (div_t >= {1'b0, dvs_q});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc_in) state_d = S_RES;
			end
			S_RES: begin
				if (kind_q == cfp_pkg::K_MUL && mul_go) state_d = S_MUL;
				else if (kind_q == cfp_pkg::K_DIV && div_go) state_d = S_DIV;
				else state_d = S_WB;
			end
			S_MUL: begin
				if (mul_last) state_d = S_WB;
			end
			S_DIV: begin
				if (div_last) state_d = S_DFIN;
			end
			S_DFIN: state_d = S_WB;
			S_WB: begin
				if (wb_go) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			known_q   <= '0;
			out_valid <= 1'b0;
			mcnt_q    <= '0;
			dcnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_RES) begin
				mcnt_q <= '0;
				dcnt_q <= '0;
			end
			if (state_q == S_MUL) mcnt_q <= mcnt_q + MCW'(1);
			if (state_q == S_DIV) dcnt_q <= dcnt_q + DCW'(1);
			if (wb_go && tgt_ok) known_q[tgt_addr] <= fold_q;
			if (wb_go) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			kind_q <= kind;
			fl_q   <= first_is_literal;
			flit_q <= first_literal;
			fvar_q <= first_variable;
			sl_q   <= second_is_literal;
			slit_q <= second_literal;
			svar_q <= second_variable;
			tgt_q  <= target_variable;
			ka_q   <= !first_is_literal && id_ok(first_variable)
			          && known_q[id_addr(first_variable)];
			kb_q   <= !second_is_literal && id_ok(second_variable)
			          && known_q[id_addr(second_variable)];
		end

		unique case (state_q)
			S_RES: begin
				a_q  <= a_res;
				b_q  <= b_res;
				ca_q <= ca;
				cb_q <= cb;
				unique case (kind_q)
					cfp_pkg::K_ADD: begin
						fold_q <= ca && cb;
						r_q    <= a_res + b_res;
					end
					cfp_pkg::K_SUB: begin
						fold_q <= ca && cb;
						r_q    <= a_res - b_res;
					end
					cfp_pkg::K_MUL: begin
						fold_q <= mul_go;
						acc_q  <= '0;
					end
					cfp_pkg::K_DIV: begin
						fold_q <= div_go;
						acc_q  <= magnitude(a_res);
						dvs_q  <= magnitude(b_res);
						rem_q  <= '0;
						neg_q  <= a_res[VB-1] ^ b_res[VB-1];
					end
					cfp_pkg::K_ASSIGN: begin
						fold_q <= ca;
						r_q    <= a_res;
					end
					default: fold_q <= 1'b0;
				endcase
			end
			S_MUL: begin
				acc_q <= acc_q + part;
				r_q   <= acc_q + part;
			end
			S_DIV: begin
				rem_q <= div_ge ? div_sub[VB-1:0] : div_t[VB-1:0];
				acc_q <= {acc_q[VB-2:0], div_ge};
			end
			S_DFIN: r_q <= neg_q ? (~acc_q) + VB'(1) : acc_q;
			default: ;
		endcase

		if (wb_go) begin
			removed               <= fold_q;
			out_kind              <= kind_q;
			out_first_is_literal  <= ca_q;
			out_first_literal     <= ca_q ? val_to_32(a_q) : '0;
			out_first_variable    <= ca_q ? '0 : fvar_q;
			out_second_is_literal <= cb_q;
			out_second_literal    <= cb_q ? val_to_32(b_q) : '0;
			out_second_variable   <= cb_q ? '0 : svar_q;
			out_target_variable   <= tgt_q;
			folded_value          <= fold_q ? val_to_32(r_q) : '0;
		end
	end

	a_accept_res: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |=> state_q == S_RES)
		else $error("transfer not followed by resolve");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> dvs_q != '0)
		else $error("divider running on zero divisor");

	a_known_set: assert property (@(posedge clk) disable iff (!arst_n)
		(wb_go && fold_q && tgt_ok) |=> known_q[tgt_addr])
		else $error("folded target not marked known");

	a_out_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_WB)
		else $error("result valid without write-back");

endmodule

// ===== rtl/core/cfp_ram.sv =====
// ----------------------------------------------------------------------------
// cfp_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module cfp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== verif/constant_fold_propagate_checker.sv =====
// ----------------------------------------------------------------------------
// constant_fold_propagate_checker
// Watches both channels of the constant fold/propagate core. Keeps its own
// table of variables known to hold constants, works out the result of every
// instruction the core takes in, and compares each result transfer, field by
// field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module constant_fold_propagate_checker (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    in_valid,
	input  logic                    in_stall,
	input  cfp_pkg::kind_t          kind,
	input  logic                    first_is_literal,
	input  logic signed [31:0]      first_literal,
	input  cfp_pkg::var_id_t        first_variable,
	input  logic                    second_is_literal,
	input  logic signed [31:0]      second_literal,
	input  cfp_pkg::var_id_t        second_variable,
	input  cfp_pkg::var_id_t        target_variable,

	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic                    removed,
	input  cfp_pkg::kind_t          out_kind,
	input  logic                    out_first_is_literal,
	input  logic signed [31:0]      out_first_literal,
	input  cfp_pkg::var_id_t        out_first_variable,
	input  logic                    out_second_is_literal,
	input  logic signed [31:0]      out_second_literal,
	input  cfp_pkg::var_id_t        out_second_variable,
	input  cfp_pkg::var_id_t        out_target_variable,
	input  logic signed [31:0]      folded_value,

	output int                      errors,
	output int                      pending
);

	import cfp_pkg::*;

	localparam int NUM_VARS = 1 << ID_BITS;

	typedef struct packed {
		logic    removed;
		kind_t   kind;
		logic    f_lit;
		lit_t    f_val;
		var_id_t f_var;
		logic    s_lit;
		lit_t    s_val;
		var_id_t s_var;
		var_id_t tgt;
		lit_t    folded;
	} fold_result_t;

	fold_result_t         fold_results_q[$];
	fold_result_t         want;
	logic [NUM_VARS-1:0]  known_var;
	lit_t                 var_value [NUM_VARS];
	int                   err_count = 0;
	int                   waiting = 0;

	assign errors  = err_count;
	assign pending = waiting;

	// signed divide, truncating toward zero; most negative / -1 wraps
	function automatic lit_t signed_quotient(lit_t a, lit_t b);
		lit_t ma, mb, q;
		ma = a[LIT_BITS-1] ? -a : a;
		mb = b[LIT_BITS-1] ? -b : b;
		q  = ma / mb;
		return (a[LIT_BITS-1] != b[LIT_BITS-1]) ? -q : q;
	endfunction

	function automatic fold_result_t fold_and_record(kind_t k, logic fl, lit_t fv,
			var_id_t fvar, logic sl, lit_t sv, var_id_t svar, var_id_t tgt);
		fold_result_t r;
		logic         a_const, b_const, fold;
		lit_t         a, b, v;
		a_const = fl || known_var[fvar];
		b_const = sl || known_var[svar];
		a = fl ? fv : (known_var[fvar] ? var_value[fvar] : '0);
		b = sl ? sv : (known_var[svar] ? var_value[svar] : '0);
		fold = 1'b0;
		v = '0;
		case (k)
			K_ADD: if (a_const && b_const) begin
				v = a + b;
				fold = 1'b1;
			end
			K_SUB: if (a_const && b_const) begin
				v = a - b;
				fold = 1'b1;
			end
			K_MUL: if (a_const && b_const) begin
				v = a * b;
				fold = 1'b1;
			end
			K_DIV: if (a_const && b_const && b != '0) begin
				v = signed_quotient(a, b);
				fold = 1'b1;
			end
			K_ASSIGN: if (a_const) begin
				v = a;
				fold = 1'b1;
			end
			default: fold = 1'b0;
		endcase
		known_var[tgt] = fold;
		if (fold)
			var_value[tgt] = v;
		r.removed = fold;
		r.kind    = k;
		r.f_lit   = a_const;
		r.f_val   = a;
		r.f_var   = a_const ? '0 : fvar;
		r.s_lit   = b_const;
		r.s_val   = b;
		r.s_var   = b_const ? '0 : svar;
		r.tgt     = tgt;
		r.folded  = v;
		return r;
	endfunction

	task automatic match_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
			err_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_var = '0;
			fold_results_q.delete();
			waiting = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (fold_results_q.size() == 0) begin
					$display("%0t: result transfer with no instruction outstanding", $time);
					err_count++;
				end else begin
					want = fold_results_q.pop_front();
					match_field("removed", 32'(want.removed), 32'(removed));
					match_field("out_kind", 32'(want.kind), 32'(out_kind));
					match_field("out_first_is_literal", 32'(want.f_lit),
						32'(out_first_is_literal));
					match_field("out_first_literal", want.f_val, out_first_literal);
					match_field("out_first_variable", 32'(want.f_var),
						32'(out_first_variable));
					match_field("out_second_is_literal", 32'(want.s_lit),
						32'(out_second_is_literal));
					match_field("out_second_literal", want.s_val, out_second_literal);
					match_field("out_second_variable", 32'(want.s_var),
						32'(out_second_variable));
					match_field("out_target_variable", 32'(want.tgt),
						32'(out_target_variable));
					match_field("folded_value", want.folded, folded_value);
				end
			end
			if (in_valid && !in_stall)
				fold_results_q.push_back(fold_and_record(kind, first_is_literal,
					first_literal, first_variable, second_is_literal, second_literal,
					second_variable, target_variable));
			waiting = fold_results_q.size();
		end
	end

endmodule

// ===== verif/constant_fold_propagate_core_tb.sv =====
// ----------------------------------------------------------------------------
// constant_fold_propagate_core_tb
// Drives instruction transfers into the constant fold/propagate core: a short
// directed sequence (extremes, every operator, divide corner cases, latest
// definition wins) followed by random instruction streams over a small set of
// variables so constants propagate. Sender and receiver idle at random, and
// one long receiver hold-off backs the core up. The checker does the scoring.
// ----------------------------------------------------------------------------
module constant_fold_propagate_core_tb;

	import cfp_pkg::*;

	localparam int    QUIET_LIMIT  = 2000;
	localparam int    HOLD_CYCLES  = 80;
	localparam int    DRAIN_CYCLES = 60;
	localparam int    PHASE_ITEMS  = 230;
	localparam kind_t K_SPARE6     = 3'd6;
	localparam kind_t K_SPARE7     = 3'd7;
	localparam lit_t  LIT_MAX      = 32'h7FFF_FFFF;
	localparam lit_t  LIT_MIN      = 32'h8000_0000;
	localparam lit_t  LIT_NEG1     = 32'hFFFF_FFFF;

	typedef struct {
		kind_t   kind;
		logic    f_lit;
		lit_t    f_val;
		var_id_t f_var;
		logic    s_lit;
		lit_t    s_val;
		var_id_t s_var;
		var_id_t tgt;
	} instr_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	kind_t              kind;
	logic               first_is_literal;
	logic signed [31:0] first_literal;
	var_id_t            first_variable;
	logic               second_is_literal;
	logic signed [31:0] second_literal;
	var_id_t            second_variable;
	var_id_t            target_variable;
	logic               out_valid;
	logic               out_stall;
	logic               removed;
	kind_t              out_kind;
	logic               out_first_is_literal;
	logic signed [31:0] out_first_literal;
	var_id_t            out_first_variable;
	logic               out_second_is_literal;
	logic signed [31:0] out_second_literal;
	var_id_t            out_second_variable;
	var_id_t            out_target_variable;
	logic signed [31:0] folded_value;
	int                 errors;
	int                 pending;

	int                 in_idle_pct = 0;
	int                 out_idle_pct = 0;
	bit                 hold_req = 1'b0;
	bit                 hold_done = 1'b0;
	int                 quiet_cycles = 0;
	instr_t             directed_q[$];

	constant_fold_propagate_core dut (.*);

	constant_fold_propagate_checker checker_i (.*);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic instr_t mk(kind_t k, logic fl, lit_t fv, var_id_t fvar,
			logic sl, lit_t sv, var_id_t svar, var_id_t t);
		instr_t i;
		i.kind  = k;
		i.f_lit = fl;
		i.f_val = fv;
		i.f_var = fvar;
		i.s_lit = sl;
		i.s_val = sv;
		i.s_var = svar;
		i.tgt   = t;
		return i;
	endfunction

	function automatic lit_t pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 32'd1;
			2: return LIT_NEG1;
			3: return LIT_MAX;
			4: return LIT_MIN;
			5, 6: return lit_t'($urandom_range(0, 40)) - 32'd20;
			default: return $urandom;
		endcase
	endfunction

	function automatic var_id_t pick_var();
		return ($urandom_range(0, 99) < 85) ? var_id_t'($urandom_range(0, 7))
			: var_id_t'($urandom_range(0, 31));
	endfunction

	function automatic instr_t random_instr();
		instr_t i;
		int     r;
		r = $urandom_range(0, 99);
		if (r < 22)
			i.kind = K_ADD;
		else if (r < 40)
			i.kind = K_SUB;
		else if (r < 58)
			i.kind = K_MUL;
		else if (r < 72)
			i.kind = K_DIV;
		else if (r < 90)
			i.kind = K_ASSIGN;
		else
			i.kind = kind_t'($urandom_range(K_OTHER, K_SPARE7));
		i.f_lit = ($urandom_range(0, 99) < 40);
		i.f_val = pick_value();
		i.f_var = pick_var();
		i.s_lit = ($urandom_range(0, 99) < 45);
		i.s_val = pick_value();
		i.s_var = pick_var();
		i.tgt   = pick_var();
		return i;
	endfunction

	task automatic send_instr(input instr_t i);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid          <= 1'b1;
		kind              <= i.kind;
		first_is_literal  <= i.f_lit;
		first_literal     <= i.f_val;
		first_variable    <= i.f_var;
		second_is_literal <= i.s_lit;
		second_literal    <= i.s_val;
		second_variable   <= i.s_var;
		target_variable   <= i.tgt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// receiver: random stall, plus one long hold-off on request
	initial begin
		out_stall = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			out_stall <= ($urandom_range(0, 99) < out_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n            = 1'b0;
		in_valid          = 1'b0;
		kind              = K_ADD;
		first_is_literal  = 1'b0;
		first_literal     = '0;
		first_variable    = '0;
		second_is_literal = 1'b0;
		second_literal    = '0;
		second_variable   = '0;
		target_variable   = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing known yet after reset
		directed_q.push_back(mk(K_ADD, 1'b0, '0, 5'd1, 1'b0, '0, 5'd2, 5'd3));
		directed_q.push_back(mk(K_ASSIGN, 1'b1, LIT_MAX, 5'd31, 1'b1, '0, 5'd31, 5'd1));
		directed_q.push_back(mk(K_ASSIGN, 1'b1, LIT_MIN, 5'd0, 1'b0, '0, 5'd9, 5'd2));
		directed_q.push_back(mk(K_ADD, 1'b0, '0, 5'd1, 1'b0, '0, 5'd2, 5'd3));
		directed_q.push_back(mk(K_SUB, 1'b0, '0, 5'd2, 1'b1, 32'd1, 5'd0, 5'd4));
		directed_q.push_back(mk(K_MUL, 1'b0, '0, 5'd1, 1'b0, '0, 5'd1, 5'd5));
		directed_q.push_back(mk(K_DIV, 1'b0, '0, 5'd2, 1'b1, LIT_NEG1, 5'd0, 5'd6));
		directed_q.push_back(mk(K_DIV, 1'b1, -32'sd7, 5'd0, 1'b1, 32'd2, 5'd0, 5'd7));
		directed_q.push_back(mk(K_DIV, 1'b1, 32'd7, 5'd0, 1'b1, -32'sd2, 5'd0, 5'd7));
		directed_q.push_back(mk(K_DIV, 1'b0, '0, 5'd1, 1'b1, '0, 5'd0, 5'd8));
		directed_q.push_back(mk(K_ADD, 1'b0, '0, 5'd8, 1'b1, 32'd1, 5'd0, 5'd9));
		directed_q.push_back(mk(K_OTHER, 1'b1, 32'd3, 5'd0, 1'b1, 32'd4, 5'd0, 5'd1));
		directed_q.push_back(mk(K_ADD, 1'b0, '0, 5'd1, 1'b0, '0, 5'd3, 5'd10));
		directed_q.push_back(mk(K_ASSIGN, 1'b0, '0, 5'd3, 1'b0, '0, 5'd20, 5'd11));
		directed_q.push_back(mk(K_ASSIGN, 1'b0, '0, 5'd20, 1'b0, '0, 5'd3, 5'd12));
		directed_q.push_back(mk(K_SPARE6, 1'b1, 32'd5, 5'd0, 1'b1, 32'd6, 5'd0, 5'd13));
		directed_q.push_back(mk(K_SPARE7, 1'b1, LIT_NEG1, 5'd31, 1'b1, LIT_NEG1, 5'd31,
			5'd14));
		directed_q.push_back(mk(K_ASSIGN, 1'b1, 32'd5, 5'd0, 1'b1, '0, 5'd0, 5'd3));
		directed_q.push_back(mk(K_ASSIGN, 1'b1, 32'd9, 5'd0, 1'b1, '0, 5'd0, 5'd3));
		directed_q.push_back(mk(K_ADD, 1'b0, '0, 5'd3, 1'b0, '0, 5'd3, 5'd15));
		directed_q.push_back(mk(K_ADD, 1'b1, LIT_MAX, 5'd31, 1'b1, LIT_MAX, 5'd31, 5'd31));
		directed_q.push_back(mk(K_MUL, 1'b1, LIT_MIN, 5'd31, 1'b1, LIT_NEG1, 5'd31, 5'd0));
		directed_q.push_back(mk(K_SUB, 1'b0, '0, 5'd0, 1'b0, '0, 5'd31, 5'd16));
		directed_q.push_back(mk(K_DIV, 1'b0, '0, 5'd31, 1'b0, '0, 5'd0, 5'd17));

		in_idle_pct  = 18;
		out_idle_pct = 71;
		foreach (directed_q[n])
			send_instr(directed_q[n]);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					in_idle_pct  = 18;
					out_idle_pct = 71;
				end
				1: begin
					in_idle_pct  = 71;
					out_idle_pct = 18;
				end
				default: begin
					in_idle_pct  = 0;
					out_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 0 && n == 40)
					hold_req = 1'b1;
				send_instr(random_instr());
			end
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending != 0)
			$display("%0t: %0d results never arrived", $time, pending);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/cfp_pkg.sv
rtl/core/cfp_ram.sv
rtl/core/constant_fold_propagate_core.sv
verif/constant_fold_propagate_checker.sv
verif/constant_fold_propagate_core_tb.sv
